// File: rtl/gsem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsem_pkg
// Shared constants and helpers for the Gaussian/Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package gsem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 11;

    // 1/159 as a fixed-point reciprocal, exact for sums below 114912
    localparam int          RECIP_SHIFT = 23;
    localparam logic [15:0] RECIP_159   = 16'd52759;

    localparam logic [DIM_W-1:0] DIM_MIN = 11'd8;
    localparam logic [DIM_W-1:0] W_MAX   = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_MAX   = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] W_RESET = 11'd420;
    localparam logic [DIM_W-1:0] H_RESET = 11'd280;

    // register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // 5x5 Gaussian weight at (row, column)
    function automatic logic [3:0] gauss_weight(input int r, input int c);
        logic [3:0] w;
        int         d;
        d = (r < 2 ? r : 4 - r) * 3 + (c < 2 ? c : 4 - c);
        case (d)
            0:       w = 4'd2;
            1:       w = 4'd4;
            2:       w = 4'd5;
            3:       w = 4'd4;
            4:       w = 4'd9;
            5:       w = 4'd12;
            6:       w = 4'd5;
            7:       w = 4'd12;
            8:       w = 4'd15;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/gaussian_sobel_edge_magnitude.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_sobel_edge_magnitude
// 5x5 Gaussian blur, 3x3 Sobel and clamped integer gradient magnitude.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s       | in  | i_s_tvalid/o_s_tready | tdata: pixel; tuser: filler
//  m       | out | o_m_tvalid/i_m_tready | tdata: magnitude,row,col; tlast
//  cfg     | in  | i_cfg_valid/o_cfg_ready | index, data
//
//  One item at a time passes through: read of the column in both line RAMs, a
//  two-level Gaussian sum, reciprocal multiply, Sobel, and an 8-step square
//  root. A result sits in an output register; the next item is taken while
//  it waits, but if it is still not taken when the next result is ready,
//  the block stalls. Reset is synchronous; the line RAMs are not cleared.
// ----------------------------------------------------------------------------
module gaussian_sobel_edge_magnitude
    import gsem_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] pixel
    input  wire logic        i_s_tuser,   // [0] filler
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [31:0] o_m_tdata,   // [7:0] magnitude, [17:8] out_row,
                                          // [27:18] out_col, [31:28] zero
    output logic             o_m_tlast,   // last_of_frame
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_ROW  = 4'd2;
    localparam logic [3:0] ST_TOT  = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_BLR  = 4'd5;
    localparam logic [3:0] ST_GRD  = 4'd6;
    localparam logic [3:0] ST_SQ   = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0]        r_state;
    logic [DIM_W-1:0]  r_w, r_h;
    logic [DIM_W-1:0]  r_i;          // row of next item, flush rows included
    logic [ADDR_W-1:0] r_j;
    logic [9:0]        r_orow, r_ocol;

    // per-item latched context
    logic [7:0]        r_x;
    logic [1:0]        r_islot;
    logic [ADDR_W-1:0] r_v;
    logic              r_bslot;
    logic              r_gcond, r_scond, r_prod_en, r_last;
    logic [9:0]        r_prow, r_pcol;

    logic [7:0]  r_raw [5][5];
    logic [7:0]  r_blr [3][3];
    logic [13:0] r_rsum [5];
    logic [15:0] r_sum;
    logic [31:0] r_prod;
    logic [15:0] r_bdat;
    logic [20:0] r_sq;
    logic [7:0]  r_root;
    logic [2:0]  r_bit;

    logic        r_ovalid;
    logic [7:0]  r_omag;
    logic [9:0]  r_oro, r_oco;
    logic        r_olast;

    // RAM ports
    logic              raw_we, raw_re, blr_we, blr_re;
    logic [ADDR_W-1:0] raw_raddr, blr_raddr;
    logic [31:0]       raw_wdata, raw_rdata;
    logic [15:0]       blr_wdata, blr_rdata;

    logic              s_acc, cfg_acc;
    logic [DIM_W-1:0]  cfg_sat;

    // accept-time decode
    logic              a_x_zero, a_prod, a_last, a_jwrap;
    logic signed [11:0] a_u;
    logic [DIM_W-1:0]  a_v;
    logic [7:0]        bval;
    logic [7:0]        col [5];
    logic signed [11:0] gx, gy;
    logic [7:0]        sq_t;
    logic              fin_go;
    logic              fin_load;

    gsem_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_raw_ram (
        .i_clk   (i_clk),
        .i_we    (raw_we),
        .i_waddr (r_j),
        .i_wdata (raw_wdata),
        .i_re    (raw_re),
        .i_raddr (raw_raddr),
        .o_rdata (raw_rdata)
    );

    gsem_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_blr_ram (
        .i_clk   (i_clk),
        .i_we    (blr_we),
        .i_waddr (r_v),
        .i_wdata (blr_wdata),
        .i_re    (blr_re),
        .i_raddr (blr_raddr),
        .o_rdata (blr_rdata)
    );

    assign o_s_tready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // register saturation
    always_comb begin
        cfg_sat = i_cfg_data;
        if (i_cfg_data < DIM_MIN) begin
            cfg_sat = DIM_MIN;
        end else if (i_cfg_index == CFG_WIDTH && i_cfg_data > W_MAX) begin
            cfg_sat = W_MAX;
        end else if (i_cfg_index == CFG_HEIGHT && i_cfg_data > H_MAX) begin
            cfg_sat = H_MAX;
        end
    end

    // item decode at accept
    always_comb begin
        a_x_zero = i_s_tuser || (r_i >= r_h);
        a_prod   = (r_i > 11'd3) || (r_i == 11'd3 && r_j >= ADDR_W'(3));
        a_last   = a_prod && ({1'b0, r_ocol} == r_w - 11'd1)
                          && ({1'b0, r_orow} == r_h - 11'd1);
        a_jwrap  = ({1'b0, r_j} + 11'd1) >= r_w;
        if (r_j >= ADDR_W'(2)) begin
            a_u = $signed({1'b0, r_i}) - 12'sd2;
            a_v = {1'b0, r_j} - 11'd2;
        end else begin
            a_u = $signed({1'b0, r_i}) - 12'sd3;
            a_v = {1'b0, r_j} + r_w - 11'd2;
        end
    end

    assign raw_re    = s_acc;
    assign blr_re    = s_acc;
    assign raw_raddr = r_j;
    assign blr_raddr = a_v[ADDR_W-1:0];

    // column entering the raw window, and raw write-back
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            col[k] = raw_rdata[8*(2'(r_islot + 2'(k))) +: 8];
        end
        col[4]    = r_x;
        raw_wdata = raw_rdata;
        raw_wdata[8*r_islot +: 8] = r_x;
    end
    assign raw_we = (r_state == ST_RD);

    // blurred value and blur write-back
    assign bval      = r_gcond ? r_prod[RECIP_SHIFT +: 8] : 8'd0;
    assign blr_we    = (r_state == ST_BLR);
    always_comb begin
        blr_wdata = r_bdat;
        blr_wdata[8*r_bslot +: 8] = bval;
    end

    // Sobel gradients
    always_comb begin
        gx = 12'(r_blr[0][2]) + (12'(r_blr[1][2]) <<< 1) + 12'(r_blr[2][2])
           - 12'(r_blr[0][0]) - (12'(r_blr[1][0]) <<< 1) - 12'(r_blr[2][0]);
        gy = 12'(r_blr[0][0]) + (12'(r_blr[0][1]) <<< 1) + 12'(r_blr[0][2])
           - 12'(r_blr[2][0]) - (12'(r_blr[2][1]) <<< 1) - 12'(r_blr[2][2]);
    end

    assign sq_t     = r_root | (8'd128 >> r_bit);
    assign fin_go   = !r_prod_en || !r_ovalid || i_m_tready;
    assign fin_load = (r_state == ST_FIN) && fin_go && r_prod_en;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_w      <= W_RESET;
            r_h      <= H_RESET;
            r_i      <= '0;
            r_j      <= '0;
            r_orow   <= '0;
            r_ocol   <= '0;
            r_ovalid <= 1'b0;
            r_bit    <= '0;
        end else begin
            // output register: load a new result or drop a taken one
            if (fin_load) begin
                r_ovalid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (cfg_acc) begin
                        if (i_cfg_index == CFG_WIDTH) begin
                            r_w <= cfg_sat;
                        end else begin
                            r_h <= cfg_sat;
                        end
                        r_i    <= '0;
                        r_j    <= '0;
                        r_orow <= '0;
                        r_ocol <= '0;
                    end else if (s_acc) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD:  r_state <= ST_ROW;
                ST_ROW: r_state <= ST_TOT;
                ST_TOT: r_state <= ST_MUL;
                ST_MUL: r_state <= ST_BLR;
                ST_BLR: r_state <= ST_GRD;
                ST_GRD: begin
                    r_state <= ST_SQ;
                    r_bit   <= '0;
                end
                ST_SQ: begin
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_go) begin
                        r_state <= ST_IDLE;
                        // advance frame position
                        if (r_last) begin
                            r_i    <= '0;
                            r_j    <= '0;
                            r_orow <= '0;
                            r_ocol <= '0;
                        end else begin
                            if (({1'b0, r_j} + 11'd1) >= r_w) begin
                                r_j <= '0;
                                r_i <= r_i + 11'd1;
                            end else begin
                                r_j <= r_j + ADDR_W'(1);
                            end
                            if (r_prod_en) begin
                                if ({1'b0, r_ocol} == r_w - 11'd1) begin
                                    r_ocol <= '0;
                                    r_orow <= r_orow + 10'd1;
                                end else begin
                                    r_ocol <= r_ocol + 10'd1;
                                end
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 5; r++) begin
                for (int c = 0; c < 5; c++) begin
                    r_raw[r][c] <= '0;
                end
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_blr[r][c] <= '0;
                end
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_x       <= a_x_zero ? 8'd0 : i_s_tdata;
                        r_islot   <= r_i[1:0];
                        r_v       <= a_v[ADDR_W-1:0];
                        r_bslot   <= a_u[0];
                        r_gcond   <= (r_i >= 11'd4) && (r_i <= r_h - 11'd1)
                                     && (r_j >= ADDR_W'(4));
                        r_scond   <= (a_v >= 11'd2) && (a_u >= 12'sd2)
                                     && (a_u <= $signed({1'b0, r_h}) - 12'sd1);
                        r_prod_en <= a_prod;
                        r_last    <= a_last;
                        r_prow    <= r_orow;
                        r_pcol    <= r_ocol;
                        // a wrap does not matter here; frame advance is at the end
                        if (a_jwrap) begin
                            r_root <= '0;
                        end
                    end
                end
                ST_RD: begin
                    for (int r = 0; r < 5; r++) begin
                        for (int c = 0; c < 4; c++) begin
                            r_raw[r][c] <= r_raw[r][c+1];
                        end
                        r_raw[r][4] <= col[r];
                    end
                    r_bdat <= blr_rdata;
                end
                ST_ROW: begin
                    for (int r = 0; r < 5; r++) begin
                        logic [13:0] acc;
                        acc = '0;
                        for (int c = 0; c < 5; c++) begin
                            acc = acc + 14'(r_raw[r][c]) * 14'(gauss_weight(r, c));
                        end
                        r_rsum[r] <= acc;
                    end
                end
                ST_TOT: begin
                    r_sum <= 16'(r_rsum[0]) + 16'(r_rsum[1]) + 16'(r_rsum[2])
                           + 16'(r_rsum[3]) + 16'(r_rsum[4]);
                end
                ST_MUL: begin
                    r_prod <= r_sum * RECIP_159;
                end
                ST_BLR: begin
                    for (int r = 0; r < 3; r++) begin
                        r_blr[r][0] <= r_blr[r][1];
                        r_blr[r][1] <= r_blr[r][2];
                    end
                    r_blr[0][2] <= r_bdat[8*r_bslot +: 8];
                    r_blr[1][2] <= r_bdat[8*(!r_bslot) +: 8];
                    r_blr[2][2] <= bval;
                end
                ST_GRD: begin
                    r_sq   <= r_scond ? 21'(22'(gx) * 22'(gx)) + 21'(22'(gy) * 22'(gy))
                                      : 21'd0;
                    r_root <= '0;
                end
                ST_SQ: begin
                    if (21'(sq_t) * 21'(sq_t) <= r_sq) begin
                        r_root <= sq_t;
                    end
                end
                ST_FIN: begin
                    if (fin_go && r_prod_en) begin
                        r_omag  <= r_root;
                        r_oro   <= r_prow;
                        r_oco   <= r_pcol;
                        r_olast <= r_last;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'd0, r_oco, r_oro, r_omag};
    assign o_m_tlast  = r_olast;

endmodule
`default_nettype wire

// File: rtl/gsem_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsem_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gsem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire
